// ===== hdl/lqritc_pkg.sv =====
package lqritc_pkg;

    // Controller dimensions
    localparam int NUM_STATES   = 12;
    localparam int NUM_OUTPUTS  = 4;
    localparam int NUM_TRACKED  = 3;
    localparam int TRACKED_BASE = 9;

    // Word widths
    localparam int DATA_W = 32;
    localparam int DT_W   = 31;
    localparam int TIME_W = 48;
    localparam int FRAC_W = 16;
    localparam int IDX_W  = 7;
    localparam int MODE_W = 2;
    localparam int ACT_W  = 2;

    // Multiplier and accumulator
    localparam int OPND_W = DATA_W + 1;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = PROD_W;
    localparam int ONE_Q  = 2 ** FRAC_W;

    localparam logic [DT_W-1:0] DT_RESET = DT_W'(655);

    // Coefficient table layout, column-major
    localparam int TABLE_DEPTH = 128;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int K1_BASE     = 0;
    localparam int KX_BASE     = K1_BASE + NUM_OUTPUTS * NUM_TRACKED;
    localparam int TRIM_BASE   = KX_BASE + NUM_OUTPUTS * NUM_STATES;
    localparam int SLOPE_BASE  = TRIM_BASE + NUM_OUTPUTS;
    localparam int OFFSET_BASE = SLOPE_BASE + NUM_TRACKED;
    localparam int CADDR_RAW   = $clog2(OFFSET_BASE + NUM_TRACKED);
    localparam int CADDR_W     = (CADDR_RAW > TABLE_AW) ? CADDR_RAW : TABLE_AW;

    // Index widths
    localparam int SADDR_W = $clog2(NUM_STATES);
    localparam int TSI_W   = (TRACKED_BASE + NUM_TRACKED > 1) ?
                             $clog2(TRACKED_BASE + NUM_TRACKED) : 1;
    localparam int TK_W    = (NUM_TRACKED > 1) ? $clog2(NUM_TRACKED) : 1;
    localparam int OUT_W   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

    // Input word modes
    localparam logic [MODE_W-1:0] MODE_COEF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // Sub-steps of one reference / error computation
    localparam logic [1:0] REF_HI  = 2'd0;
    localparam logic [1:0] REF_LO  = 2'd1;
    localparam logic [1:0] REF_OFS = 2'd2;
    localparam logic [1:0] REF_ERR = 2'd3;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_REF,
        SQ_GAP_ERR,
        SQ_K1,
        SQ_GAP_ROW,
        SQ_DT,
        SQ_KX,
        SQ_TRIM
    } seq_state_t;

    typedef enum logic [1:0] {
        A_COEF,
        A_ROW,
        A_ONE
    } a_sel_t;

    typedef enum logic [2:0] {
        B_STATE,
        B_THI,
        B_TLO,
        B_ERR,
        B_DT,
        B_ONE
    } b_sel_t;

    typedef enum logic [2:0] {
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_SATSUB,
        ACC_INTADD
    } acc_op_t;

    typedef enum logic [2:0] {
        CM_NONE,
        CM_ERR,
        CM_ROW,
        CM_INTEG,
        CM_CMD
    } commit_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_word_t;

    typedef struct packed {
        logic [ACT_W-1:0]         actuator_index;
        logic signed [DATA_W-1:0] actuator_value;
        logic                     last_actuator;
    } out_word_t;

    // One multiply-accumulate micro-op from the sequencer
    typedef struct packed {
        logic                valid;
        logic [CADDR_W-1:0]  caddr;
        logic                coef_zero;
        logic [SADDR_W-1:0]  saddr;
        logic                state_zero;
        a_sel_t              a_sel;
        b_sel_t              b_sel;
        logic                shift;
        acc_op_t             acc_op;
        commit_t             commit;
        logic [TK_W-1:0]     tk;
        logic [OUT_W-1:0]    oi;
        logic                last_out;
    } uop_t;

    // Table and state vector write port
    typedef struct packed {
        logic              coef_we;
        logic              state_we;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

    // Saturate accumulator to a 32-bit signed word
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if (top == '0 || top == '1) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hdl/lqritc_seq.sv =====
module lqritc_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              out_busy,
    output logic              busy,
    output lqritc_pkg::uop_t  uop
);

    lqritc_pkg::seq_state_t                state_reg, state_next;
    logic [lqritc_pkg::TK_W-1:0]           k_reg, k_next;
    logic [lqritc_pkg::OUT_W-1:0]          i_reg, i_next;
    logic [lqritc_pkg::SADDR_W-1:0]        j_reg, j_next;
    logic [lqritc_pkg::TSI_W-1:0]          ts;
    logic                                  k_last, i_last, j_last;

    assign k_last = (k_reg == lqritc_pkg::TK_W'(lqritc_pkg::NUM_TRACKED - 1));
    assign i_last = (i_reg == lqritc_pkg::OUT_W'(lqritc_pkg::NUM_OUTPUTS - 1));
    assign j_last = (j_reg == lqritc_pkg::SADDR_W'(lqritc_pkg::NUM_STATES - 1));

    // state element tracked by reference k
    assign ts = lqritc_pkg::TSI_W'(lqritc_pkg::TRACKED_BASE) + lqritc_pkg::TSI_W'(k_reg);

    assign busy = (state_reg != lqritc_pkg::SQ_IDLE);

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lqritc_pkg::SQ_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // Micro-op issue, one multiply per cycle outside the gap states and the trim wait
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        uop          = '0;
        uop.shift    = 1'b1;
        uop.oi       = i_reg;
        uop.tk       = k_reg;
        uop.a_sel    = lqritc_pkg::A_COEF;
        uop.b_sel    = lqritc_pkg::B_ONE;
        uop.acc_op   = lqritc_pkg::ACC_ADD;
        uop.commit   = lqritc_pkg::CM_NONE;

        unique case (state_reg)
            lqritc_pkg::SQ_IDLE: begin
                if (start) begin
                    state_next = lqritc_pkg::SQ_REF;
                    k_next     = '0;
                    j_next     = '0;
                end
            end

            // ref = sat(slope*t + offset), err = sat(ref - x)
            lqritc_pkg::SQ_REF: begin
                uop.valid = 1'b1;
                unique case (j_reg[1:0])
                    lqritc_pkg::REF_HI: begin
                        uop.caddr  = lqritc_pkg::CADDR_W'(lqritc_pkg::SLOPE_BASE)
                                   + lqritc_pkg::CADDR_W'(k_reg);
                        uop.b_sel  = lqritc_pkg::B_THI;
                        uop.shift  = 1'b0;
                        uop.acc_op = lqritc_pkg::ACC_LOAD;
                    end
                    lqritc_pkg::REF_LO: begin
                        uop.caddr  = lqritc_pkg::CADDR_W'(lqritc_pkg::SLOPE_BASE)
                                   + lqritc_pkg::CADDR_W'(k_reg);
                        uop.b_sel  = lqritc_pkg::B_TLO;
                    end
                    lqritc_pkg::REF_OFS: begin
                        uop.caddr  = lqritc_pkg::CADDR_W'(lqritc_pkg::OFFSET_BASE)
                                   + lqritc_pkg::CADDR_W'(k_reg);
                        uop.b_sel  = lqritc_pkg::B_ONE;
                    end
                    lqritc_pkg::REF_ERR: begin
                        uop.a_sel      = lqritc_pkg::A_ONE;
                        uop.b_sel      = lqritc_pkg::B_STATE;
                        uop.saddr      = lqritc_pkg::SADDR_W'(ts);
                        uop.state_zero = (ts >= lqritc_pkg::NUM_STATES);
                        uop.acc_op     = lqritc_pkg::ACC_SATSUB;
                        uop.commit     = lqritc_pkg::CM_ERR;
                    end
                endcase
                if (j_reg[1:0] == lqritc_pkg::REF_ERR) begin
                    j_next = '0;
                    if (k_last) begin
                        state_next = lqritc_pkg::SQ_GAP_ERR;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end

            // errors must land before K1 reads them
            lqritc_pkg::SQ_GAP_ERR: begin
                state_next = lqritc_pkg::SQ_K1;
                i_next     = '0;
                k_next     = '0;
            end

            // row sum of K1 * err
            lqritc_pkg::SQ_K1: begin
                uop.valid  = 1'b1;
                uop.caddr  = lqritc_pkg::CADDR_W'(lqritc_pkg::K1_BASE)
                           + lqritc_pkg::CADDR_W'(i_reg)
                           + lqritc_pkg::CADDR_W'(k_reg)
                             * lqritc_pkg::CADDR_W'(lqritc_pkg::NUM_OUTPUTS);
                uop.b_sel  = lqritc_pkg::B_ERR;
                uop.acc_op = (k_reg == '0) ? lqritc_pkg::ACC_LOAD : lqritc_pkg::ACC_ADD;
                if (k_last) begin
                    uop.commit = lqritc_pkg::CM_ROW;
                    state_next = lqritc_pkg::SQ_GAP_ROW;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end

            // row sum must land before the dt multiply
            lqritc_pkg::SQ_GAP_ROW: begin
                state_next = lqritc_pkg::SQ_DT;
            end

            lqritc_pkg::SQ_DT: begin
                uop.valid  = 1'b1;
                uop.a_sel  = lqritc_pkg::A_ROW;
                uop.b_sel  = lqritc_pkg::B_DT;
                uop.acc_op = lqritc_pkg::ACC_INTADD;
                uop.commit = lqritc_pkg::CM_INTEG;
                state_next = lqritc_pkg::SQ_KX;
                j_next     = '0;
            end

            // integrator - Kx * x
            lqritc_pkg::SQ_KX: begin
                uop.valid  = 1'b1;
                uop.caddr  = lqritc_pkg::CADDR_W'(lqritc_pkg::KX_BASE)
                           + lqritc_pkg::CADDR_W'(i_reg)
                           + lqritc_pkg::CADDR_W'(j_reg)
                             * lqritc_pkg::CADDR_W'(lqritc_pkg::NUM_OUTPUTS);
                uop.b_sel  = lqritc_pkg::B_STATE;
                uop.saddr  = j_reg;
                uop.acc_op = (j_reg == '0) ? lqritc_pkg::ACC_SATSUB : lqritc_pkg::ACC_SUB;
                if (j_last) begin
                    state_next = lqritc_pkg::SQ_TRIM;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end

            // add trim and emit; held until the output register is free
            lqritc_pkg::SQ_TRIM: begin
                if (!out_busy) begin
                    uop.valid    = 1'b1;
                    uop.caddr    = lqritc_pkg::CADDR_W'(lqritc_pkg::TRIM_BASE)
                                 + lqritc_pkg::CADDR_W'(i_reg);
                    uop.b_sel    = lqritc_pkg::B_ONE;
                    uop.commit   = lqritc_pkg::CM_CMD;
                    uop.last_out = i_last;
                    if (i_last) begin
                        state_next = lqritc_pkg::SQ_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        k_next     = '0;
                        state_next = lqritc_pkg::SQ_K1;
                    end
                end
            end
        endcase

        uop.coef_zero = (uop.caddr >= lqritc_pkg::TABLE_DEPTH);
    end

    a_cmd_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (uop.valid && uop.commit == lqritc_pkg::CM_CMD) |-> !out_busy)
        else $error("command issued while output register occupied");

    a_end_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy) |-> $past(uop.valid && uop.commit == lqritc_pkg::CM_CMD && uop.last_out))
        else $error("step ended without final command");

endmodule

// ===== hdl/lqritc_core.sv =====
module lqritc_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lqritc_pkg::mem_wr_t           mem_wr,
    input  logic                          int_clear,
    input  lqritc_pkg::uop_t              uop,
    input  logic [lqritc_pkg::TIME_W-1:0] elapsed,
    input  logic [lqritc_pkg::DT_W-1:0]   dt,
    output logic                          res_valid,
    output lqritc_pkg::out_word_t         res
);

    // Coefficient table and state vector, synchronous read
    logic [lqritc_pkg::DATA_W-1:0] coef_mem  [lqritc_pkg::TABLE_DEPTH];
    logic [lqritc_pkg::DATA_W-1:0] state_mem [lqritc_pkg::NUM_STATES];
    logic [lqritc_pkg::DATA_W-1:0] coef_rd_reg, state_rd_reg;

    lqritc_pkg::uop_t u1_reg, u2_reg;

    logic signed [lqritc_pkg::OPND_W-1:0] a_op, b_op;
    logic signed [lqritc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [lqritc_pkg::ACC_W-1:0]  term, acc_reg, acc_next;
    logic signed [lqritc_pkg::DATA_W-1:0] acc_sat, sat_val, int_sel;

    logic signed [lqritc_pkg::DATA_W-1:0] row_reg;
    logic signed [lqritc_pkg::DATA_W-1:0] err_reg [lqritc_pkg::NUM_TRACKED];
    logic signed [lqritc_pkg::DATA_W-1:0] int_reg [lqritc_pkg::NUM_OUTPUTS];

    // Memory ports
    always_ff @(posedge aclk) begin
        if (mem_wr.coef_we) begin
            coef_mem[mem_wr.addr[lqritc_pkg::TABLE_AW-1:0]] <= mem_wr.data;
        end
        coef_rd_reg <= coef_mem[uop.caddr[lqritc_pkg::TABLE_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (mem_wr.state_we) begin
            state_mem[mem_wr.addr[lqritc_pkg::SADDR_W-1:0]] <= mem_wr.data;
        end
        state_rd_reg <= state_mem[uop.saddr];
    end

    // Op tags follow the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u1_reg <= '0;
            u2_reg <= '0;
        end else begin
            u1_reg <= uop;
            u2_reg <= u1_reg;
        end
    end

    // Operand select
    always_comb begin
        unique case (u1_reg.a_sel)
            lqritc_pkg::A_COEF:
                a_op = u1_reg.coef_zero ? '0 : {coef_rd_reg[lqritc_pkg::DATA_W-1], coef_rd_reg};
            lqritc_pkg::A_ROW:
                a_op = {row_reg[lqritc_pkg::DATA_W-1], row_reg};
            lqritc_pkg::A_ONE:
                a_op = lqritc_pkg::OPND_W'(lqritc_pkg::ONE_Q);
            default:
                a_op = '0;
        endcase
        unique case (u1_reg.b_sel)
            lqritc_pkg::B_STATE:
                b_op = u1_reg.state_zero ? '0
                     : {state_rd_reg[lqritc_pkg::DATA_W-1], state_rd_reg};
            lqritc_pkg::B_THI:
                b_op = {1'b0, elapsed[lqritc_pkg::TIME_W-1:lqritc_pkg::FRAC_W]};
            lqritc_pkg::B_TLO:
                b_op = {{(lqritc_pkg::OPND_W-lqritc_pkg::FRAC_W){1'b0}},
                        elapsed[lqritc_pkg::FRAC_W-1:0]};
            lqritc_pkg::B_ERR:
                b_op = {err_reg[u1_reg.tk][lqritc_pkg::DATA_W-1], err_reg[u1_reg.tk]};
            lqritc_pkg::B_DT:
                b_op = {{(lqritc_pkg::OPND_W-lqritc_pkg::DT_W){1'b0}}, dt};
            lqritc_pkg::B_ONE:
                b_op = lqritc_pkg::OPND_W'(lqritc_pkg::ONE_Q);
            default:
                b_op = '0;
        endcase
        prod_next = a_op * b_op;
    end

    // Shared multiplier, registered
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // Accumulate
    always_comb begin
        term    = u2_reg.shift ? (prod_reg >>> lqritc_pkg::FRAC_W) : prod_reg;
        acc_sat = lqritc_pkg::sat32(acc_reg);
        int_sel = int_reg[u2_reg.oi];
        unique case (u2_reg.acc_op)
            lqritc_pkg::ACC_LOAD:   acc_next = term;
            lqritc_pkg::ACC_ADD:    acc_next = acc_reg + term;
            lqritc_pkg::ACC_SUB:    acc_next = acc_reg - term;
            lqritc_pkg::ACC_SATSUB:
                acc_next = {{(lqritc_pkg::ACC_W-lqritc_pkg::DATA_W){acc_sat[lqritc_pkg::DATA_W-1]}},
                            acc_sat} - term;
            lqritc_pkg::ACC_INTADD:
                acc_next = {{(lqritc_pkg::ACC_W-lqritc_pkg::DATA_W){int_sel[lqritc_pkg::DATA_W-1]}},
                            int_sel} + term;
            default:                acc_next = acc_reg;
        endcase
        sat_val = lqritc_pkg::sat32(acc_next);
    end

    always_ff @(posedge aclk) begin
        if (u2_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (u2_reg.valid && u2_reg.commit == lqritc_pkg::CM_ERR) begin
            err_reg[u2_reg.tk] <= sat_val;
        end
        if (u2_reg.valid && u2_reg.commit == lqritc_pkg::CM_ROW) begin
            row_reg <= sat_val;
        end
    end

    // Integrators: cleared on reset and restart
    always_ff @(posedge aclk) begin
        if (!aresetn || int_clear) begin
            int_reg <= '{default: '0};
        end else if (u2_reg.valid && u2_reg.commit == lqritc_pkg::CM_INTEG) begin
            int_reg[u2_reg.oi] <= sat_val;
        end
    end

    assign res_valid          = u2_reg.valid && (u2_reg.commit == lqritc_pkg::CM_CMD);
    assign res.actuator_index = lqritc_pkg::ACT_W'(u2_reg.oi);
    assign res.actuator_value = sat_val;
    assign res.last_actuator  = u2_reg.last_out;

    a_err_hazard: assert property (@(posedge aclk) disable iff (!aresetn)
        (u1_reg.valid && u1_reg.b_sel == lqritc_pkg::B_ERR)
        |-> !(u2_reg.valid && u2_reg.commit == lqritc_pkg::CM_ERR))
        else $error("error term read while being written");

    a_row_hazard: assert property (@(posedge aclk) disable iff (!aresetn)
        (u1_reg.valid && u1_reg.a_sel == lqritc_pkg::A_ROW)
        |-> !(u2_reg.valid && u2_reg.commit == lqritc_pkg::CM_ROW))
        else $error("row sum read while being written");

endmodule

// ===== hdl/lqr_integral_tracking_controller.sv =====
// Channel  Ports                      Word
// input    s_valid s_ready s_data     mode, index, value, last
// result   m_valid m_ready m_data     actuator_index, actuator_value, last_actuator
// config   cfg_valid cfg_ready        cfg_data: time step dt, unsigned Q15.16
//
// Coefficient, state and restart words are accepted one per cycle while no step runs.
// A state word with last set runs a control step, paced by the single shared 33x33
// multiplier doing one product per cycle outside the gap states and the wait for a
// free result register; the final command passes the operand, product and result
// registers before it shows on m_valid. The input is held off during a step. Reset
// clears integrators, elapsed time and sets dt to 655; the table and state vector
// hold garbage until written. A stalled result register holds the step before each
// command's final add.
module lqr_integral_tracking_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lqritc_pkg::in_word_t          s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lqritc_pkg::out_word_t         m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lqritc_pkg::DT_W-1:0]   cfg_data
);

    logic                            accept, start, int_clear, busy, res_valid;
    logic [lqritc_pkg::DT_W-1:0]     dt_reg;
    logic [lqritc_pkg::TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                            m_valid_reg, m_valid_next;
    lqritc_pkg::out_word_t           m_data_reg, res;
    lqritc_pkg::mem_wr_t             mem_wr;
    lqritc_pkg::uop_t                uop;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !busy;
    assign cfg_ready = 1'b1;

    // Input word decode
    assign start     = accept && (s_data.mode == lqritc_pkg::MODE_STATE) && s_data.last;
    assign int_clear = accept && (s_data.mode == lqritc_pkg::MODE_RESTART);

    always_comb begin
        mem_wr.coef_we  = accept && (s_data.mode == lqritc_pkg::MODE_COEF);
        mem_wr.state_we = accept && (s_data.mode == lqritc_pkg::MODE_STATE)
                          && (s_data.index < lqritc_pkg::NUM_STATES);
        mem_wr.addr     = s_data.index;
        mem_wr.data     = s_data.value;
    end

    // Elapsed time advances by dt at each step and restarts at dt on a restart word
    always_comb begin
        elapsed_next = elapsed_reg;
        if (start) begin
            elapsed_next = elapsed_reg + lqritc_pkg::TIME_W'(dt_reg);
        end else if (int_clear) begin
            elapsed_next = lqritc_pkg::TIME_W'(dt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg      <= lqritc_pkg::DT_RESET;
            elapsed_reg <= '0;
        end else begin
            elapsed_reg <= elapsed_next;
            if (cfg_valid && cfg_ready) begin
                dt_reg <= cfg_data;
            end
        end
    end

    lqritc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_busy (m_valid_reg),
        .busy     (busy),
        .uop      (uop)
    );

    lqritc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mem_wr    (mem_wr),
        .int_clear (int_clear),
        .uop       (uop),
        .elapsed   (elapsed_reg),
        .dt        (dt_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !m_valid_reg)
        else $error("result word overwritten");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy)
        else $error("control step did not start");

endmodule
